### rtl/hsv2rgb_pkg.sv
`default_nettype none
package hsv2rgb_pkg;

	localparam int HUE_W = 12;
	localparam int MILLI_W = 10;
	localparam int LEVEL_W = 8;
	localparam int QUO_W = 7;
	localparam int REM_W = 6;
	localparam int SPAN_W = 16;
	localparam int AREA_W = 20;
	localparam int PROD_W = 30;
	localparam int RECIP_W = 31;

	localparam logic [MILLI_W-1:0] FULL_MILLI = 10'd1000;
	localparam logic [SPAN_W-1:0] FULL_SPAN = 16'd60000;

	localparam int DIV60_SHIFT = 20;
	localparam logic [14:0] DIV60_MULT = 15'd17477;
	localparam int DIV6_SHIFT = 8;
	localparam logic [5:0] DIV6_MULT = 6'd43;

	localparam int RECIP_SHIFT = 52;
	localparam logic [RECIP_W-1:0] LEVEL_RECIP = 31'd1125899907;

	typedef enum logic [2:0] {
		SEXT_RED_YELLOW,
		SEXT_YELLOW_GREEN,
		SEXT_GREEN_CYAN,
		SEXT_CYAN_BLUE,
		SEXT_BLUE_MAGENTA,
		SEXT_MAGENTA_RED
	} sextant_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

endpackage
`default_nettype wire

### rtl/hsv_in_if.sv
`default_nettype none
interface hsv_in_if;
	import hsv2rgb_pkg::*;

	logic               valid;
	logic               ready;
	logic [HUE_W-1:0]   hue_degrees;
	logic [MILLI_W-1:0] saturation_milli;
	logic [MILLI_W-1:0] brightness_milli;

	modport source (
		output valid, hue_degrees, saturation_milli, brightness_milli,
		input  ready
	);

	modport sink (
		input  valid, hue_degrees, saturation_milli, brightness_milli,
		output ready
	);

endinterface
`default_nettype wire

### rtl/rgb_out_if.sv
`default_nettype none
interface rgb_out_if;
	import hsv2rgb_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source (
		output valid, red_level, green_level, blue_level,
		input  ready
	);

	modport sink (
		input  valid, red_level, green_level, blue_level,
		output ready
	);

endinterface
`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
`default_nettype none
// Converts one HSV word per clock, unless the output side stalls, into
// truncated 8-bit red, green and blue levels. Each word passes through six
// register stages; the depth is set by the hue split into sextant and
// remainder (two stages), the forming of the three channel products (one
// stage), the two multiplications of each channel lane and the output
// register. Stages hold their word while the next one is full and stalled,
// and empty stages still take new words, so input ready only drops once the
// whole pipeline is occupied.
module hsv_to_rgb_converter (
	input  logic       clk,
	input  logic       arst_n,
	hsv_in_if.sink     pixel_in,
	rgb_out_if.source  pixel_out
);
	import hsv2rgb_pkg::*;

	pipe_en_t           en;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [MILLI_W-1:0] sat_clamp, bri_clamp;
	logic [MILLI_W-1:0] sat_s1, bri_s1, sat_s2, bri_s2, bri_s3;
	logic [REM_W-1:0]   rem_s2;
	sextant_t           sext_s2, sext_s3, sext_s4, sext_s5;

	logic [SPAN_W-1:0]  sat_rem, sat_x60;
	logic [SPAN_W-1:0]  span_p, span_q, span_t;
	logic [AREA_W-1:0]  area_p_s3, area_q_s3, area_t_s3;
	logic [AREA_W-1:0]  area_full;

	logic [LEVEL_W-1:0] full_s5, p_s5, q_s5, t_s5;
	logic [LEVEL_W-1:0] red_s6, green_s6, blue_s6;

	assign en.s6 = !v_s6 || pixel_out.ready;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign pixel_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= pixel_in.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	assign sat_clamp = (pixel_in.saturation_milli > FULL_MILLI) ?
		FULL_MILLI : pixel_in.saturation_milli;
	assign bri_clamp = (pixel_in.brightness_milli > FULL_MILLI) ?
		FULL_MILLI : pixel_in.brightness_milli;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sat_s1 <= sat_clamp;
			bri_s1 <= bri_clamp;
		end
		if (en.s2) begin
			sat_s2 <= sat_s1;
			bri_s2 <= bri_s1;
		end
	end

	hsv2rgb_hue u_hue (
		.clk     (clk),
		.en      (en),
		.hue     (pixel_in.hue_degrees),
		.rem_s2  (rem_s2),
		.sext_s2 (sext_s2)
	);

	// All spans are over the denominator 60000, so zero saturation needs no
	// special handling: every span then equals the full span.
	assign sat_rem = sat_s2 * rem_s2;
	assign sat_x60 = {sat_s2, 6'b0} - {4'b0, sat_s2, 2'b0};
	assign span_p  = FULL_SPAN - sat_x60;
	assign span_q  = FULL_SPAN - sat_rem;
	assign span_t  = FULL_SPAN - sat_x60 + sat_rem;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			area_p_s3 <= {span_p, 4'b0} + {4'b0, span_p};
			area_q_s3 <= {span_q, 4'b0} + {4'b0, span_q};
			area_t_s3 <= {span_t, 4'b0} + {4'b0, span_t};
			bri_s3    <= bri_s2;
			sext_s3   <= sext_s2;
		end
		if (en.s4) sext_s4 <= sext_s3;
		if (en.s5) sext_s5 <= sext_s4;
	end

	assign area_full = {FULL_SPAN, 4'b0} + {4'b0, FULL_SPAN};

	hsv2rgb_lane u_lane_full (
		.clk (clk), .en (en), .bri (bri_s3), .area (area_full), .level_s5 (full_s5)
	);

	hsv2rgb_lane u_lane_p (
		.clk (clk), .en (en), .bri (bri_s3), .area (area_p_s3), .level_s5 (p_s5)
	);

	hsv2rgb_lane u_lane_q (
		.clk (clk), .en (en), .bri (bri_s3), .area (area_q_s3), .level_s5 (q_s5)
	);

	hsv2rgb_lane u_lane_t (
		.clk (clk), .en (en), .bri (bri_s3), .area (area_t_s3), .level_s5 (t_s5)
	);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			unique case (sext_s5)
				SEXT_RED_YELLOW: begin
					red_s6   <= full_s5;
					green_s6 <= t_s5;
					blue_s6  <= p_s5;
				end
				SEXT_YELLOW_GREEN: begin
					red_s6   <= q_s5;
					green_s6 <= full_s5;
					blue_s6  <= p_s5;
				end
				SEXT_GREEN_CYAN: begin
					red_s6   <= p_s5;
					green_s6 <= full_s5;
					blue_s6  <= t_s5;
				end
				SEXT_CYAN_BLUE: begin
					red_s6   <= p_s5;
					green_s6 <= q_s5;
					blue_s6  <= full_s5;
				end
				SEXT_BLUE_MAGENTA: begin
					red_s6   <= t_s5;
					green_s6 <= p_s5;
					blue_s6  <= full_s5;
				end
				default: begin
					red_s6   <= full_s5;
					green_s6 <= p_s5;
					blue_s6  <= q_s5;
				end
			endcase
		end
	end

	assign pixel_out.valid       = v_s6;
	assign pixel_out.red_level   = red_s6;
	assign pixel_out.green_level = green_s6;
	assign pixel_out.blue_level  = blue_s6;

endmodule
`default_nettype wire

### rtl/hsv2rgb_hue.sv
`default_nettype none
module hsv2rgb_hue (
	input  logic                             clk,
	input  hsv2rgb_pkg::pipe_en_t            en,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
	output logic [hsv2rgb_pkg::REM_W-1:0]    rem_s2,
	output hsv2rgb_pkg::sextant_t            sext_s2
);
	import hsv2rgb_pkg::*;

	logic [HUE_W+15-1:0] quo_prod;
	logic [HUE_W-1:0]    hue_s1;
	logic [QUO_W-1:0]    quo_s1;
	logic [HUE_W:0]      quo_x60;
	logic [HUE_W:0]      rem_full;
	logic [QUO_W+6-1:0]  div6_prod;
	logic [4:0]          turns;
	logic [QUO_W-1:0]    turns_x6;
	logic [QUO_W-1:0]    sext_full;

	// Hue over sixty by a reciprocal that is exact over the whole 12-bit range.
	assign quo_prod = hue * DIV60_MULT;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			hue_s1 <= hue;
			quo_s1 <= quo_prod[DIV60_SHIFT +: QUO_W];
		end
	end

	assign quo_x60   = {quo_s1, 6'b0} - {4'b0, quo_s1, 2'b0};
	assign rem_full  = {1'b0, hue_s1} - quo_x60;
	assign div6_prod = quo_s1 * DIV6_MULT;
	assign turns     = div6_prod[DIV6_SHIFT +: 5];
	assign turns_x6  = {turns, 2'b0} + {1'b0, turns, 1'b0};
	assign sext_full = quo_s1 - turns_x6;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rem_s2  <= rem_full[REM_W-1:0];
			sext_s2 <= sextant_t'(sext_full[2:0]);
		end
	end

endmodule
`default_nettype wire

### rtl/hsv2rgb_lane.sv
`default_nettype none
module hsv2rgb_lane (
	input  logic                              clk,
	input  hsv2rgb_pkg::pipe_en_t             en,
	input  logic [hsv2rgb_pkg::MILLI_W-1:0]   bri,
	input  logic [hsv2rgb_pkg::AREA_W-1:0]    area,
	output logic [hsv2rgb_pkg::LEVEL_W-1:0]   level_s5
);
	import hsv2rgb_pkg::*;

	logic [PROD_W-1:0]         prod_s4;
	logic [PROD_W+RECIP_W-1:0] scaled;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4 <= bri * area;
		end
	end

	// The division by the common denominator is a reciprocal multiplication
	// whose error stays below one step of the quotient.
	assign scaled = prod_s4 * LEVEL_RECIP;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			level_s5 <= scaled[RECIP_SHIFT +: LEVEL_W];
		end
	end

endmodule
`default_nettype wire

### tb/sv/hsv_rgb_checker.sv
`default_nettype none
module hsv_rgb_checker (
	input  logic  clk,
	input  logic  arst_n,
	hsv_in_if     pix_in,
	rgb_out_if    pix_out,
	output int    mismatch_count,
	output int    pending_words,
	output int    checked_words
);
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [HUE_W-1:0]   hue;
		logic [MILLI_W-1:0] sat;
		logic [MILLI_W-1:0] bri;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} rgb_expect_t;

	rgb_expect_t expected_rgb_q[$];

	function automatic rgb_expect_t convert_pixel(
		input logic [HUE_W-1:0]   hue,
		input logic [MILLI_W-1:0] sat,
		input logic [MILLI_W-1:0] bri
	);
		rgb_expect_t      px;
		longint unsigned  h;
		longint unsigned  s;
		longint unsigned  b;
		longint unsigned  rem;
		longint unsigned  full;
		longint unsigned  p;
		longint unsigned  q;
		longint unsigned  t;
		sextant_t         sext;
		px.hue = hue;
		px.sat = sat;
		px.bri = bri;
		h = longint'(hue) % 360;
		s = (sat > FULL_MILLI) ? 1000 : longint'(sat);
		b = (bri > FULL_MILLI) ? 1000 : longint'(bri);
		full = (b * 255) / 1000;
		if (s == 0) begin
			px.red = full[LEVEL_W-1:0];
			px.green = full[LEVEL_W-1:0];
			px.blue = full[LEVEL_W-1:0];
		end else begin
			sext = sextant_t'(h / 60);
			rem = h % 60;
			p = (b * (1000 - s) * 255) / 1000000;
			q = (b * (60000 - s * rem) * 255) / 60000000;
			t = (b * (60000 - s * (60 - rem)) * 255) / 60000000;
			case (sext)
				SEXT_RED_YELLOW: begin
					px.red = full[7:0]; px.green = t[7:0]; px.blue = p[7:0];
				end
				SEXT_YELLOW_GREEN: begin
					px.red = q[7:0]; px.green = full[7:0]; px.blue = p[7:0];
				end
				SEXT_GREEN_CYAN: begin
					px.red = p[7:0]; px.green = full[7:0]; px.blue = t[7:0];
				end
				SEXT_CYAN_BLUE: begin
					px.red = p[7:0]; px.green = q[7:0]; px.blue = full[7:0];
				end
				SEXT_BLUE_MAGENTA: begin
					px.red = t[7:0]; px.green = p[7:0]; px.blue = full[7:0];
				end
				default: begin
					px.red = full[7:0]; px.green = p[7:0]; px.blue = q[7:0];
				end
			endcase
		end
		return px;
	endfunction

	always @(posedge clk) begin
		rgb_expect_t head;
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_rgb_q.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("checker: unexpected RGB word %0d %0d %0d",
							pix_out.red_level, pix_out.green_level, pix_out.blue_level);
					mismatch_count <= mismatch_count + 1;
				end else begin
					head = expected_rgb_q.pop_front();
					checked_words <= checked_words + 1;
					if (pix_out.red_level !== head.red || pix_out.green_level !== head.green
							|| pix_out.blue_level !== head.blue) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("checker: hsv %0d %0d %0d expected rgb %0d %0d %0d got %0d %0d %0d",
								head.hue, head.sat, head.bri, head.red, head.green, head.blue,
								pix_out.red_level, pix_out.green_level, pix_out.blue_level);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (pix_in.valid && pix_in.ready)
				expected_rgb_q.push_back(convert_pixel(pix_in.hue_degrees,
					pix_in.saturation_milli, pix_in.brightness_milli));
			pending_words <= expected_rgb_q.size();
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int WORDS_PER_PHASE = 260;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 20;

	typedef enum int {
		PACE_STEADY,
		PACE_SPARSE_SEND,
		PACE_SLOW_SINK,
		PACE_MIXED
	} pace_t;

	logic clk = 1'b0;
	logic arst_n;

	hsv_in_if  pix_in ();
	rgb_out_if pix_out ();

	int mismatch_count;
	int pending_words;
	int checked_words;
	int words_sent;
	int quiet_cycles;
	int send_idle_pct;
	int stall_pct;
	logic hold_off_req;
	logic hold_off_done;

	hsv_to_rgb_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pix_in),
		.pixel_out (pix_out)
	);

	hsv_rgb_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_in         (pix_in),
		.pix_out        (pix_out),
		.mismatch_count (mismatch_count),
		.pending_words  (pending_words),
		.checked_words  (checked_words)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [MILLI_W-1:0] pick_milli();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return '0;
			1: return FULL_MILLI;
			2: return MILLI_W'($urandom_range(1023, 1001));
			default: return MILLI_W'($urandom_range(999, 1));
		endcase
	endfunction

	function automatic logic [HUE_W-1:0] pick_hue();
		if ($urandom_range(3) == 0)
			return HUE_W'($urandom_range(359));
		return HUE_W'($urandom_range(4095));
	endfunction

	task automatic send_pixel(
		input logic [HUE_W-1:0]   hue,
		input logic [MILLI_W-1:0] sat,
		input logic [MILLI_W-1:0] bri
	);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.hue_degrees <= hue;
		pix_in.saturation_milli <= sat;
		pix_in.brightness_milli <= bri;
		do
			@(posedge clk);
		while (!pix_in.ready);
		words_sent++;
	endtask

	task automatic drain_pipeline();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	initial begin
		pix_out.ready = 1'b0;
		hold_off_done = 1'b0;
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				pix_out.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				pix_out.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", quiet_cycles);
				$display("tb_top: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		pace_t pace;
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.hue_degrees = '0;
		pix_in.saturation_milli = '0;
		pix_in.brightness_milli = '0;
		hold_off_req = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(12'd0, 10'd0, 10'd0);
		send_pixel(12'd0, 10'd0, 10'd1000);
		send_pixel(12'd4095, 10'd1023, 10'd1023);
		send_pixel(12'd0, 10'd1000, 10'd1000);
		send_pixel(12'd59, 10'd1000, 10'd1000);
		send_pixel(12'd60, 10'd1000, 10'd1000);
		send_pixel(12'd119, 10'd1000, 10'd1000);
		send_pixel(12'd120, 10'd750, 10'd1000);
		send_pixel(12'd180, 10'd1000, 10'd999);
		send_pixel(12'd240, 10'd500, 10'd1000);
		send_pixel(12'd300, 10'd1000, 10'd1);
		send_pixel(12'd359, 10'd1000, 10'd1000);
		send_pixel(12'd360, 10'd1000, 10'd1000);
		send_pixel(12'd720, 10'd1, 10'd1000);
		send_pixel(12'd3600, 10'd0, 10'd500);
		send_pixel(12'd100, 10'd1001, 10'd1001);
		send_pixel(12'd200, 10'd1023, 10'd0);
		send_pixel(12'd4000, 10'd0, 10'd1023);
		send_pixel(12'd2730, 10'd341, 10'd682);
		send_pixel(12'd1365, 10'd682, 10'd341);
		drain_pipeline();

		for (int p = PACE_STEADY; p <= PACE_MIXED; p++) begin
			pace = pace_t'(p);
			case (pace)
				PACE_STEADY: begin
					send_idle_pct = 0; stall_pct = 0; hold_off_req = 1'b1;
				end
				PACE_SPARSE_SEND: begin
					send_idle_pct = 87; stall_pct = 0;
				end
				PACE_SLOW_SINK: begin
					send_idle_pct = 0; stall_pct = 87;
				end
				default: begin
					send_idle_pct = 28; stall_pct = 28;
				end
			endcase
			repeat (WORDS_PER_PHASE)
				send_pixel(pick_hue(), pick_milli(), pick_milli());
			drain_pipeline();
		end

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d HSV words over four pacing phases, one with a long output hold-off.",
			words_sent);
		$display("Checked %0d RGB words, %0d mismatches, %0d left outstanding.",
			checked_words, mismatch_count, pending_words);
		if (mismatch_count == 0 && pending_words == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
